// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fgr_pkg.sv -----
package fgr_pkg;

	// Glyph geometry.
	localparam int SCALE      = 2;
	localparam int FONT_ROWS  = 7;
	localparam int FONT_COLS  = 5;
	localparam int ROWS       = FONT_ROWS * SCALE;
	localparam int COLS       = FONT_COLS * SCALE;
	localparam int MASK_W     = 10;
	localparam int GLYPH_BITS = FONT_ROWS * FONT_COLS;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int FR_W       = $clog2(FONT_ROWS);
	localparam int IDX_W      = 6;

	// Field widths.
	localparam int CODE_W  = 8;
	localparam int POS_W   = 13;
	localparam int COORD_W = 14;
	localparam int DATA_W  = 32;
	localparam int PITCH_W = 16;
	localparam int PROD_W  = COORD_W + PITCH_W + 1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_ROW_PITCH     = 2'd2,
		REG_FRAME_BASE    = 2'd3
	} cfg_reg_t;

	localparam logic [POS_W-1:0]   RST_SCREEN_WIDTH  = 13'd1024;
	localparam logic [POS_W-1:0]   RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 16'd4096;
	localparam logic [DATA_W-1:0]  RST_FRAME_BASE    = 32'd0;

	typedef struct packed {
		logic [POS_W-1:0]   screen_width;
		logic [POS_W-1:0]   screen_height;
		logic [PITCH_W-1:0] row_pitch_bytes;
		logic [DATA_W-1:0]  frame_base_address;
	} fgr_cfg_t;

	// One row beat from the sequencer to the row pipeline.
	typedef struct packed {
		logic [IDX_W-1:0]  font_idx;
		logic [ROW_W-1:0]  row_idx;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [DATA_W-1:0] ink_color;
		logic              last;
	} fgr_beat_t;

	// Character codes the font recognizes.
	localparam logic [CODE_W-1:0] CH_LOW_A    = 8'h61;
	localparam logic [CODE_W-1:0] CH_LOW_Z    = 8'h7A;
	localparam logic [CODE_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [CODE_W-1:0] CH_A        = 8'h41;
	localparam logic [CODE_W-1:0] CH_Z        = 8'h5A;
	localparam logic [CODE_W-1:0] CH_0        = 8'h30;
	localparam logic [CODE_W-1:0] CH_9        = 8'h39;
	localparam logic [CODE_W-1:0] CH_COLON    = 8'h3A;
	localparam logic [CODE_W-1:0] CH_DOT      = 8'h2E;
	localparam logic [CODE_W-1:0] CH_DASH     = 8'h2D;
	localparam logic [CODE_W-1:0] CH_SLASH    = 8'h2F;
	localparam logic [CODE_W-1:0] CH_AT       = 8'h40;
	localparam logic [CODE_W-1:0] CH_GT       = 8'h3E;
	localparam logic [CODE_W-1:0] CH_SPACE    = 8'h20;

	// Font ROM slots.
	localparam logic [IDX_W-1:0] IDX_DIGIT0   = 6'd26;
	localparam logic [IDX_W-1:0] IDX_COLON    = 6'd36;
	localparam logic [IDX_W-1:0] IDX_DOT      = 6'd37;
	localparam logic [IDX_W-1:0] IDX_DASH     = 6'd38;
	localparam logic [IDX_W-1:0] IDX_SLASH    = 6'd39;
	localparam logic [IDX_W-1:0] IDX_AT       = 6'd40;
	localparam logic [IDX_W-1:0] IDX_GT       = 6'd41;
	localparam logic [IDX_W-1:0] IDX_SPACE    = 6'd42;
	localparam logic [IDX_W-1:0] IDX_FALLBACK = 6'd43;

	// Maps a character byte to its font slot, folding lower case to upper case.
	function automatic logic [IDX_W-1:0] font_index(logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] c;
		logic [IDX_W-1:0]  idx;
		c = code;
		if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
			c = c - CASE_OFFSET;
		end
		if (c >= CH_A && c <= CH_Z) begin
			idx = IDX_W'(c - CH_A);
		end else if (c >= CH_0 && c <= CH_9) begin
			idx = IDX_W'(c - CH_0) + IDX_DIGIT0;
		end else begin
			case (c)
				CH_COLON: idx = IDX_COLON;
				CH_DOT:   idx = IDX_DOT;
				CH_DASH:  idx = IDX_DASH;
				CH_SLASH: idx = IDX_SLASH;
				CH_AT:    idx = IDX_AT;
				CH_GT:    idx = IDX_GT;
				CH_SPACE: idx = IDX_SPACE;
				default:  idx = IDX_FALLBACK;
			endcase
		end
		return idx;
	endfunction

	// Font ROM: seven rows of five columns, top row and left column first.
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(logic [IDX_W-1:0] idx);
		logic [GLYPH_BITS-1:0] g;
		case (idx)
			6'd0:  g = 35'b01110_10001_10001_11111_10001_10001_10001;
			6'd1:  g = 35'b11110_10001_10001_11110_10001_10001_11110;
			6'd2:  g = 35'b01111_10000_10000_10000_10000_10000_01111;
			6'd3:  g = 35'b11110_10001_10001_10001_10001_10001_11110;
			6'd4:  g = 35'b11111_10000_10000_11110_10000_10000_11111;
			6'd5:  g = 35'b11111_10000_10000_11110_10000_10000_10000;
			6'd6:  g = 35'b01111_10000_10000_10111_10001_10001_01111;
			6'd7:  g = 35'b10001_10001_10001_11111_10001_10001_10001;
			6'd8:  g = 35'b11111_00100_00100_00100_00100_00100_11111;
			6'd9:  g = 35'b00111_00010_00010_00010_10010_10010_01100;
			6'd10: g = 35'b10001_10010_10100_11000_10100_10010_10001;
			6'd11: g = 35'b10000_10000_10000_10000_10000_10000_11111;
			6'd12: g = 35'b10001_11011_10101_10101_10001_10001_10001;
			6'd13: g = 35'b10001_11001_10101_10011_10001_10001_10001;
			6'd14: g = 35'b01110_10001_10001_10001_10001_10001_01110;
			6'd15: g = 35'b11110_10001_10001_11110_10000_10000_10000;
			6'd16: g = 35'b01110_10001_10001_10001_10101_10010_01101;
			6'd17: g = 35'b11110_10001_10001_11110_10100_10010_10001;
			6'd18: g = 35'b01111_10000_10000_01110_00001_00001_11110;
			6'd19: g = 35'b11111_00100_00100_00100_00100_00100_00100;
			6'd20: g = 35'b10001_10001_10001_10001_10001_10001_01110;
			6'd21: g = 35'b10001_10001_10001_10001_01010_01010_00100;
			6'd22: g = 35'b10001_10001_10001_10101_10101_11011_10001;
			6'd23: g = 35'b10001_01010_00100_00100_00100_01010_10001;
			6'd24: g = 35'b10001_01010_00100_00100_00100_00100_00100;
			6'd25: g = 35'b11111_00001_00010_00100_01000_10000_11111;
			6'd26: g = 35'b01110_10001_10011_10101_11001_10001_01110;
			6'd27: g = 35'b00100_01100_00100_00100_00100_00100_01110;
			6'd28: g = 35'b01110_10001_00001_00010_00100_01000_11111;
			6'd29: g = 35'b11110_00001_00001_01110_00001_00001_11110;
			6'd30: g = 35'b10010_10010_10010_11111_00010_00010_00010;
			6'd31: g = 35'b11111_10000_10000_11110_00001_00001_11110;
			6'd32: g = 35'b01110_10000_10000_11110_10001_10001_01110;
			6'd33: g = 35'b11111_00001_00010_00100_01000_01000_01000;
			6'd34: g = 35'b01110_10001_10001_01110_10001_10001_01110;
			6'd35: g = 35'b01110_10001_10001_01111_00001_00001_01110;
			6'd36: g = 35'b00000_00100_00100_00000_00100_00100_00000;
			6'd37: g = 35'b00000_00000_00000_00000_00000_01100_01100;
			6'd38: g = 35'b00000_00000_00000_11111_00000_00000_00000;
			6'd39: g = 35'b00001_00010_00010_00100_01000_01000_10000;
			6'd40: g = 35'b01110_10001_10111_10101_10111_10000_01110;
			6'd41: g = 35'b10000_01000_00100_00010_00100_01000_10000;
			6'd42: g = 35'b00000_00000_00000_00000_00000_00000_00000;
			default: g = 35'b11111_10001_00110_00100_00100_00000_00100;
		endcase
		return g;
	endfunction

	// One font row; bit FONT_COLS-1 is the leftmost column.
	function automatic logic [FONT_COLS-1:0] glyph_row(logic [IDX_W-1:0] idx,
			logic [FR_W-1:0] fr);
		logic [GLYPH_BITS-1:0] g;
		g = glyph_bits(idx);
		return g[(FONT_ROWS - 1 - int'(fr)) * FONT_COLS +: FONT_COLS];
	endfunction

endpackage

// ----- design/fgr_in_if.sv -----
interface fgr_in_if;
	logic                                valid;
	logic                                ready;
	logic [fgr_pkg::CODE_W-1:0]          char_code;
	logic signed [fgr_pkg::POS_W-1:0]    pos_x;
	logic signed [fgr_pkg::POS_W-1:0]    pos_y;
	logic [fgr_pkg::DATA_W-1:0]          ink_color;

	modport source (output valid, char_code, pos_x, pos_y, ink_color, input ready);
	modport sink (input valid, char_code, pos_x, pos_y, ink_color, output ready);
endinterface

// ----- design/fgr_out_if.sv -----
interface fgr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [fgr_pkg::COORD_W-1:0]  row_coord;
	logic [fgr_pkg::DATA_W-1:0]          row_address;
	logic [fgr_pkg::MASK_W-1:0]          pixel_mask;
	logic [fgr_pkg::DATA_W-1:0]          pixel_value;
	logic                                last_row;

	modport source (output valid, row_coord, row_address, pixel_mask, pixel_value,
		last_row, input ready);
	modport sink (input valid, row_coord, row_address, pixel_mask, pixel_value,
		last_row, output ready);
endinterface

// ----- design/fgr_seq.sv -----
`include "assert_macros.svh"

module fgr_seq (
	input  logic                clk,
	input  logic                arst_n,
	fgr_in_if.sink              char_in,
	input  logic                take,
	output logic                beat_valid,
	output fgr_pkg::fgr_beat_t  beat
);

	logic                              busy_q;
	logic [fgr_pkg::ROW_W-1:0]         row_q;
	logic [fgr_pkg::IDX_W-1:0]         idx_q;
	logic [fgr_pkg::POS_W-1:0]         x_q;
	logic [fgr_pkg::POS_W-1:0]         y_q;
	logic [fgr_pkg::DATA_W-1:0]        ink_q;
	logic                              at_last;
	logic                              accept;

	localparam logic [fgr_pkg::ROW_W-1:0] LAST_ROW = fgr_pkg::ROW_W'(fgr_pkg::ROWS - 1);

	// A new character is taken when idle or as the final row leaves.
	assign at_last       = (row_q == LAST_ROW);
	assign char_in.ready = !busy_q || (take && at_last);
	assign accept        = char_in.valid && char_in.ready;

	// Row counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (busy_q && take) begin
			if (at_last) begin
				busy_q <= 1'b0;
				row_q  <= '0;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// Character held for its whole run of rows; the font slot is resolved once.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= fgr_pkg::font_index(char_in.char_code);
			x_q   <= char_in.pos_x;
			y_q   <= char_in.pos_y;
			ink_q <= char_in.ink_color;
		end
	end

	assign beat_valid     = busy_q;
	assign beat.font_idx  = idx_q;
	assign beat.row_idx   = row_q;
	assign beat.pos_x     = x_q;
	assign beat.pos_y     = y_q;
	assign beat.ink_color = ink_q;
	assign beat.last      = at_last;

	`ASSERT_NOW(a_row_needs_busy, row_q != '0, busy_q, "row counter runs while idle")
	`ASSERT_NEXT(a_accept_restarts, accept, busy_q && row_q == '0,
		"accepted character does not start at the top row")

endmodule

// ----- design/fgr_pipe.sv -----
`include "assert_macros.svh"

module fgr_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  fgr_pkg::fgr_cfg_t   cfg,
	input  logic                beat_valid,
	input  fgr_pkg::fgr_beat_t  beat,
	output logic                take,
	fgr_out_if.source           row_out
);

	// Stage 1: glyph row lookup and row coordinate.
	logic                              v_s1;
	logic [fgr_pkg::FONT_COLS-1:0]     glyph_s1;
	logic [fgr_pkg::COORD_W-1:0]       row_s1;
	logic [fgr_pkg::POS_W-1:0]         x_s1;
	logic [fgr_pkg::DATA_W-1:0]        ink_s1;
	logic                              last_s1;

	// Stage 2: pitch product and pixel mask.
	logic                              v_s2;
	logic [fgr_pkg::DATA_W-1:0]        prod_s2;
	logic [fgr_pkg::MASK_W-1:0]        mask_s2;
	logic [fgr_pkg::COORD_W-1:0]       row_s2;
	logic [fgr_pkg::POS_W-1:0]         x_s2;
	logic [fgr_pkg::DATA_W-1:0]        ink_s2;
	logic                              last_s2;

	// Stage 3: address sum, held as the output register.
	logic                              v_s3;
	logic [fgr_pkg::DATA_W-1:0]        addr_s3;
	logic [fgr_pkg::MASK_W-1:0]        mask_s3;
	logic [fgr_pkg::COORD_W-1:0]       row_s3;
	logic [fgr_pkg::DATA_W-1:0]        ink_s3;
	logic                              last_s3;

	logic                              en_s1;
	logic                              en_s2;
	logic                              en_s3;
	logic [fgr_pkg::FR_W-1:0]          font_row;
	logic [fgr_pkg::COORD_W-1:0]       row_next;
	logic signed [fgr_pkg::PROD_W-1:0] prod;
	logic                              row_ok;
	logic [fgr_pkg::COORD_W-1:0]       col [fgr_pkg::MASK_W];
	logic [fgr_pkg::MASK_W-1:0]        mask_next;
	logic [fgr_pkg::DATA_W-1:0]        x_bytes;

	// A stage loads when it is empty or its successor moves on.
	assign en_s3 = !v_s3 || row_out.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign take  = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= beat_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Each font row covers SCALE screen rows.
	assign font_row = fgr_pkg::FR_W'(beat.row_idx / fgr_pkg::SCALE);
	assign row_next = {beat.pos_y[fgr_pkg::POS_W-1], beat.pos_y}
		+ fgr_pkg::COORD_W'(beat.row_idx);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			glyph_s1 <= fgr_pkg::glyph_row(beat.font_idx, font_row);
			row_s1   <= row_next;
			x_s1     <= beat.pos_x;
			ink_s1   <= beat.ink_color;
			last_s1  <= beat.last;
		end
	end

	// Row offset in bytes; the 31-bit signed product is sign extended to 32 bits.
	assign prod   = $signed(row_s1) * $signed({1'b0, cfg.row_pitch_bytes});
	assign row_ok = !row_s1[fgr_pkg::COORD_W-1]
		&& (row_s1[fgr_pkg::POS_W-1:0] < cfg.screen_height);

	// Each mask bit needs an on-screen row, a lit font column and an on-screen column.
	always_comb begin
		mask_next = '0;
		for (int i = 0; i < fgr_pkg::MASK_W; i++) begin
			col[i] = {x_s1[fgr_pkg::POS_W-1], x_s1} + fgr_pkg::COORD_W'(i);
			if (i < fgr_pkg::COLS) begin
				mask_next[i] = row_ok && !col[i][fgr_pkg::COORD_W-1]
					&& (col[i][fgr_pkg::POS_W-1:0] < cfg.screen_width)
					&& glyph_s1[fgr_pkg::FONT_COLS - 1
						- ((i / fgr_pkg::SCALE) % fgr_pkg::FONT_COLS)];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= {{(fgr_pkg::DATA_W - fgr_pkg::PROD_W){prod[fgr_pkg::PROD_W-1]}}, prod};
			mask_s2 <= mask_next;
			row_s2  <= row_s1;
			x_s2    <= x_s1;
			ink_s2  <= ink_s1;
			last_s2 <= last_s1;
		end
	end

	// Column offset in bytes, four bytes per pixel, sign extended.
	assign x_bytes = {{(fgr_pkg::DATA_W - fgr_pkg::POS_W - 2){x_s2[fgr_pkg::POS_W-1]}},
		x_s2, 2'b00};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			addr_s3 <= cfg.frame_base_address + prod_s2 + x_bytes;
			mask_s3 <= mask_s2;
			row_s3  <= row_s2;
			ink_s3  <= ink_s2;
			last_s3 <= last_s2;
		end
	end

	assign row_out.valid       = v_s3;
	assign row_out.row_coord   = $signed(row_s3);
	assign row_out.row_address = addr_s3;
	assign row_out.pixel_mask  = mask_s3;
	assign row_out.pixel_value = ink_s3;
	assign row_out.last_row    = last_s3;

	`ASSERT_NEXT(a_s2_held, v_s2 && !en_s3, v_s2, "stalled middle stage lost its row")
	`ASSERT_NEXT(a_last_moves, v_s1 && last_s1 && en_s2, v_s2 && last_s2,
		"final row flag dropped between stages")

endmodule

// ----- design/font_glyph_rasterizer.sv -----
// Draws one 5x7 font character, doubled in both directions, as fourteen row beats.
// Each character beat yields one row beat per cycle, while the output is ready, for
// rows pos_y through pos_y+13, top row first; output stalls hold the block. The row
// sequencer takes the next character in the cycle its final row moves into the
// pipeline. The sequencer loads on the taking edge, then three pipeline stages
// follow before the output: font lookup, pitch multiply and mask, address sum.
// Lower case is folded to upper case; unknown codes draw the fallback glyph.
// Rows off screen still produce a beat with an empty pixel mask. Configuration
// registers may only be written while no character is in flight.
module font_glyph_rasterizer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [fgr_pkg::DATA_W-1:0] cfg_wdata,
	fgr_in_if.sink                     char_in,
	fgr_out_if.source                  row_out
);

	fgr_pkg::fgr_cfg_t   cfg_q;
	fgr_pkg::fgr_beat_t  beat;
	logic                beat_valid;
	logic                take;

	// Configuration registers; extra high bits of the write data are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width       <= fgr_pkg::RST_SCREEN_WIDTH;
			cfg_q.screen_height      <= fgr_pkg::RST_SCREEN_HEIGHT;
			cfg_q.row_pitch_bytes    <= fgr_pkg::RST_ROW_PITCH;
			cfg_q.frame_base_address <= fgr_pkg::RST_FRAME_BASE;
		end else if (cfg_we) begin
			case (fgr_pkg::cfg_reg_t'(cfg_index))
				fgr_pkg::REG_SCREEN_WIDTH:
					cfg_q.screen_width <= cfg_wdata[fgr_pkg::POS_W-1:0];
				fgr_pkg::REG_SCREEN_HEIGHT:
					cfg_q.screen_height <= cfg_wdata[fgr_pkg::POS_W-1:0];
				fgr_pkg::REG_ROW_PITCH:
					cfg_q.row_pitch_bytes <= cfg_wdata[fgr_pkg::PITCH_W-1:0];
				fgr_pkg::REG_FRAME_BASE:
					cfg_q.frame_base_address <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Row sequencer: holds one character and steps through its rows.
	fgr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.take       (take),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	// Row pipeline: glyph row, mask with clipping, framebuffer address.
	fgr_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.beat_valid (beat_valid),
		.beat       (beat),
		.take       (take),
		.row_out    (row_out)
	);

endmodule

// ----- tb/sv/tb_font_glyph_rasterizer.sv -----
module tb_font_glyph_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ZOOM            = 2;
	localparam int ROW_BEATS       = 7 * ZOOM;
	localparam int MASK_BITS       = 10;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int TAIL_CYCLES     = 20;
	localparam int HOLD_AFTER_ROWS = 1500;
	localparam int HOLD_CYCLES     = 400;

	// Font bitmaps, 7 rows of 5 columns; bit 34 is the top left pixel.
	localparam logic [34:0] GLYPH_ROM [44] = '{
		35'b01110100011000111111100011000110001,
		35'b11110100011000111110100011000111110,
		35'b01111100001000010000100001000001111,
		35'b11110100011000110001100011000111110,
		35'b11111100001000011110100001000011111,
		35'b11111100001000011110100001000010000,
		35'b01111100001000010111100011000101111,
		35'b10001100011000111111100011000110001,
		35'b11111001000010000100001000010011111,
		35'b00111000100001000010100101001001100,
		35'b10001100101010011000101001001010001,
		35'b10000100001000010000100001000011111,
		35'b10001110111010110101100011000110001,
		35'b10001110011010110011100011000110001,
		35'b01110100011000110001100011000101110,
		35'b11110100011000111110100001000010000,
		35'b01110100011000110001101011001001101,
		35'b11110100011000111110101001001010001,
		35'b01111100001000001110000010000111110,
		35'b11111001000010000100001000010000100,
		35'b10001100011000110001100011000101110,
		35'b10001100011000110001010100101000100,
		35'b10001100011000110101101011101110001,
		35'b10001010100010000100001000101010001,
		35'b10001010100010000100001000010000100,
		35'b11111000010001000100010001000011111,
		35'b01110100011001110101110011000101110,
		35'b00100011000010000100001000010001110,
		35'b01110100010000100010001000100011111,
		35'b11110000010000101110000010000111110,
		35'b10010100101001011111000100001000010,
		35'b11111100001000011110000010000111110,
		35'b01110100001000011110100011000101110,
		35'b11111000010001000100010000100001000,
		35'b01110100011000101110100011000101110,
		35'b01110100011000101111000010000101110,
		35'b00000001000010000000001000010000000,
		35'b00000000000000000000000000110001100,
		35'b00000000000000011111000000000000000,
		35'b00001000100001000100010000100010000,
		35'b01110100011011110101101111000001110,
		35'b10000010000010000010001000100010000,
		35'b00000000000000000000000000000000000,
		35'b11111100010011000100001000000000100
	};

	typedef struct {
		logic [7:0]         code;
		logic signed [12:0] x;
		logic signed [12:0] y;
		logic [31:0]        ink;
	} char_beat_t;

	typedef struct {
		logic signed [13:0] coord;
		logic [31:0]        addr;
		logic [9:0]         mask;
		logic [31:0]        value;
		logic               last;
	} row_beat_t;

	// Lower case folds to upper case; anything the font lacks maps to the fallback.
	function automatic int glyph_slot(logic [7:0] code);
		logic [7:0] c;
		int slot;
		c = code;
		if (c >= fgr_pkg::CH_LOW_A && c <= fgr_pkg::CH_LOW_Z) begin
			c = c - fgr_pkg::CASE_OFFSET;
		end
		if (c >= fgr_pkg::CH_A && c <= fgr_pkg::CH_Z) begin
			slot = int'(c - fgr_pkg::CH_A);
		end else if (c >= fgr_pkg::CH_0 && c <= fgr_pkg::CH_9) begin
			slot = int'(fgr_pkg::IDX_DIGIT0) + int'(c - fgr_pkg::CH_0);
		end else begin
			case (c)
				fgr_pkg::CH_COLON: slot = int'(fgr_pkg::IDX_COLON);
				fgr_pkg::CH_DOT:   slot = int'(fgr_pkg::IDX_DOT);
				fgr_pkg::CH_DASH:  slot = int'(fgr_pkg::IDX_DASH);
				fgr_pkg::CH_SLASH: slot = int'(fgr_pkg::IDX_SLASH);
				fgr_pkg::CH_AT:    slot = int'(fgr_pkg::IDX_AT);
				fgr_pkg::CH_GT:    slot = int'(fgr_pkg::IDX_GT);
				fgr_pkg::CH_SPACE: slot = int'(fgr_pkg::IDX_SPACE);
				default:           slot = int'(fgr_pkg::IDX_FALLBACK);
			endcase
		end
		return slot;
	endfunction

	// Holds the screen settings and the row beats still owed by the block.
	class glyph_scoreboard;
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] pitch;
		logic [31:0] base;
		row_beat_t   rows_due[$];
		int          errors;
		int          rows_checked;
		int          chars_noted;

		function new();
			width = fgr_pkg::RST_SCREEN_WIDTH;
			height = fgr_pkg::RST_SCREEN_HEIGHT;
			pitch = fgr_pkg::RST_ROW_PITCH;
			base = fgr_pkg::RST_FRAME_BASE;
			errors = 0;
			rows_checked = 0;
			chars_noted = 0;
		endfunction

		// Registers keep only their low bits.
		function void set_reg(fgr_pkg::cfg_reg_t idx, logic [31:0] value);
			case (idx)
				fgr_pkg::REG_SCREEN_WIDTH:  width = value[12:0];
				fgr_pkg::REG_SCREEN_HEIGHT: height = value[12:0];
				fgr_pkg::REG_ROW_PITCH:     pitch = value[15:0];
				fgr_pkg::REG_FRAME_BASE:    base = value;
				default: ;
			endcase
		endfunction

		// Expands one character beat into its fourteen row beats.
		function void note_char(char_beat_t c);
			logic [34:0] glyph;
			row_beat_t   e;
			int          row;
			int          col;
			glyph = GLYPH_ROM[glyph_slot(c.code)];
			for (int r = 0; r < ROW_BEATS; r++) begin
				row = int'(c.y) + r;
				e.mask = '0;
				// Rows above or below the screen keep an empty mask.
				if (row >= 0 && row < int'(height)) begin
					for (int i = 0; i < MASK_BITS; i++) begin
						col = int'(c.x) + i;
						if (col >= 0 && col < int'(width) &&
								glyph[34 - ((r / ZOOM) * 5 + i / ZOOM)]) begin
							e.mask[i] = 1'b1;
						end
					end
				end
				e.coord = 14'(row);
				e.addr = base + 32'(row) * 32'(pitch) + 32'(int'(c.x)) * 32'd4;
				e.value = c.ink;
				e.last = (r == ROW_BEATS - 1);
				rows_due.push_back(e);
			end
			chars_noted++;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns: %s", $time, msg);
		endtask

		// Compares one row beat with the oldest one owed.
		task check_row(row_beat_t got);
			row_beat_t want;
			rows_checked++;
			if (rows_due.size() == 0) begin
				report($sformatf("row beat for row %0d arrived with none owed", got.coord));
				return;
			end
			want = rows_due.pop_front();
			if (got.coord !== want.coord) begin
				report($sformatf("beat %0d: row_coord %0d, expected %0d",
					rows_checked, got.coord, want.coord));
			end
			if (got.addr !== want.addr) begin
				report($sformatf("beat %0d: row_address %h, expected %h",
					rows_checked, got.addr, want.addr));
			end
			if (got.mask !== want.mask) begin
				report($sformatf("beat %0d: pixel_mask %b, expected %b",
					rows_checked, got.mask, want.mask));
			end
			if (got.value !== want.value) begin
				report($sformatf("beat %0d: pixel_value %h, expected %h",
					rows_checked, got.value, want.value));
			end
			if (got.last !== want.last) begin
				report($sformatf("beat %0d: last_row %b, expected %b",
					rows_checked, got.last, want.last));
			end
		endtask

		function int pending();
			return rows_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;
	bit          quiet_phase;
	int          settings_used;

	fgr_in_if  char_if();
	fgr_out_if row_if();

	glyph_scoreboard sb = new();

	font_glyph_rasterizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.char_in(char_if),
		.row_out(row_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none in a quiet phase.
	function automatic int pick_gap();
		int p;
		if (quiet_phase) begin
			return 0;
		end
		p = $urandom_range(99);
		if (p < 50) begin
			return 0;
		end
		if (p < 85) begin
			return $urandom_range(3, 1);
		end
		if (p < 96) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(70, 25);
	endfunction

	// Each call waits for a clock edge, then drives the write enable high with one register's index and data.
	task automatic write_reg(fgr_pkg::cfg_reg_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		sb.set_reg(idx, value);
	endtask

	task automatic set_screen(logic [31:0] w, logic [31:0] h, logic [31:0] p,
			logic [31:0] b);
		write_reg(fgr_pkg::REG_SCREEN_WIDTH, w);
		write_reg(fgr_pkg::REG_SCREEN_HEIGHT, h);
		write_reg(fgr_pkg::REG_ROW_PITCH, p);
		write_reg(fgr_pkg::REG_FRAME_BASE, b);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offers one character beat and returns at the edge that takes it.
	task automatic send_char(logic [7:0] code, int x, int y, logic [31:0] ink);
		char_beat_t c;
		int         gap;
		bit         took;
		c.code = code;
		c.x = 13'(x);
		c.y = 13'(y);
		c.ink = ink;
		gap = pick_gap();
		if (gap > 0) begin
			char_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.char_code <= c.code;
		char_if.pos_x <= c.x;
		char_if.pos_y <= c.y;
		char_if.ink_color <= c.ink;
		do begin
			@(negedge clk);
			took = (char_if.ready === 1'b1);
			@(posedge clk);
		end while (!took);
		sb.note_char(c);
	endtask

	// Waits until every owed row beat has come and the pipeline is quiet.
	task automatic drain();
		char_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Positions mostly straddle the visible area so clipping gets exercised.
	task automatic run_random(int count);
		logic [7:0] code;
		int         x;
		int         y;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 60) begin
				code = 8'($urandom_range(127, 32));
			end else begin
				code = 8'($urandom);
			end
			if ($urandom_range(99) < 75) begin
				x = int'($urandom_range(int'(sb.width) + 14)) - 12;
				y = int'($urandom_range(int'(sb.height) + 18)) - 16;
			end else begin
				x = int'(13'($urandom));
				y = int'(13'($urandom));
			end
			send_char(code, x, y, $urandom);
		end
	endtask

	// Output side: random stalls, plus one long hold-off once traffic is flowing.
	initial begin
		int run_left;
		int hold_left;
		int p;
		bit level;
		bit hold_done;
		run_left = 0;
		hold_left = 0;
		level = 1'b1;
		hold_done = 1'b0;
		row_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && sb.rows_checked >= HOLD_AFTER_ROWS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				row_if.ready <= 1'b0;
			end else if (quiet_phase) begin
				row_if.ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					p = $urandom_range(99);
					if (p < 65) begin
						level = 1'b1;
						run_left = $urandom_range(16, 1);
					end else if (p < 93) begin
						level = 1'b0;
						run_left = $urandom_range(3, 1);
					end else begin
						level = 1'b0;
						run_left = $urandom_range(60, 20);
					end
				end
				run_left--;
				row_if.ready <= level;
			end
		end
	end

	// Row beats are sampled mid-cycle and checked at the edge that takes them.
	initial begin
		row_beat_t got;
		bit        fired;
		forever begin
			@(negedge clk);
			fired = (arst_n && row_if.valid && row_if.ready) === 1'b1;
			got.coord = row_if.row_coord;
			got.addr = row_if.row_address;
			got.mask = row_if.pixel_mask;
			got.value = row_if.pixel_value;
			got.last = row_if.last_row;
			@(posedge clk);
			if (fired) begin
				sb.check_row(got);
			end
		end
	end

	// Watchdog.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_font_glyph_rasterizer failed");
		$finish;
	end

	initial begin
		quiet_phase = 1'b0;
		settings_used = 1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= fgr_pkg::REG_SCREEN_WIDTH;
		cfg_wdata <= '0;
		char_if.valid <= 1'b0;
		char_if.char_code <= '0;
		char_if.pos_x <= '0;
		char_if.pos_y <= '0;
		char_if.ink_color <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed characters under the reset settings: every glyph class,
		// case folding, the fallback, clipping on all four sides and the
		// extreme positions.
		send_char(fgr_pkg::CH_A, 0, 0, 32'h0000_0000);
		send_char(fgr_pkg::CH_LOW_A, 1014, 758, 32'hFFFF_FFFF);
		send_char(fgr_pkg::CH_LOW_Z, 1020, 100, 32'h1234_5678);
		send_char(fgr_pkg::CH_Z, 300, 400, 32'h8000_0001);
		send_char(fgr_pkg::CH_0, -3, -5, 32'hA5A5_A5A5);
		send_char(fgr_pkg::CH_9, -4096, -4096, 32'h5A5A_5A5A);
		send_char(fgr_pkg::CH_COLON, 4095, 4095, 32'h0F0F_0F0F);
		send_char(fgr_pkg::CH_DOT, -4096, 4095, 32'hF0F0_F0F0);
		send_char(fgr_pkg::CH_DASH, 4095, -4096, 32'h0000_FFFF);
		send_char(fgr_pkg::CH_SLASH, 200, 200, 32'hFFFF_0000);
		send_char(fgr_pkg::CH_AT, 500, 300, 32'h0BAD_F00D);
		send_char(fgr_pkg::CH_GT, 10, 754, 32'h0000_0001);
		send_char(fgr_pkg::CH_SPACE, 20, 20, 32'hFFFF_FFFE);
		send_char(8'h80, 30, 30, 32'h0123_4567);
		send_char(8'hFF, 40, 40, 32'h89AB_CDEF);
		send_char(8'h3F, 50, 50, 32'h7FFF_FFFF);
		send_char(8'h00, 60, 60, 32'h3C3C_3C3C);
		send_char(8'h60, 70, 70, 32'hC3C3_C3C3);
		send_char(8'h7B, 80, 80, 32'h1111_1111);
		drain();

		// Largest pitch and base; a size of 4096 fits in the 13-bit width and height registers.
		set_screen(32'd4096, 32'd4096, 32'd65535, 32'hFFFF_FFFF);
		run_random(50);
		drain();

		// Empty screen: every pixel is clipped.
		set_screen(32'd0, 32'd0, 32'd0, 32'd0);
		run_random(15);
		drain();

		// Oversized write data loses its high bits; no input gaps and no random output stalls.
		set_screen(32'hFFFF_FFFF, 32'h0001_2345, 32'hDEAD_0A00, 32'h1234_5678);
		quiet_phase = 1'b1;
		run_random(45);
		drain();
		quiet_phase = 1'b0;

		set_screen($urandom_range(4096, 1), $urandom_range(4096, 1),
			$urandom_range(65535), $urandom);
		run_random(50);
		drain();

		set_screen(32'd640, 32'd480, 32'd2560, 32'h8000_0000);
		run_random(50);
		drain();

		// A single visible pixel, with a base that wraps.
		set_screen(32'd1, 32'd1, 32'd4, 32'hFFFF_FFF0);
		run_random(40);
		drain();

		$display("Drew %0d characters as %0d row beats under %0d screen settings,",
			sb.chars_noted, sb.rows_checked, settings_used);
		$display("including a %0d-cycle output hold-off; %0d mismatches.",
			HOLD_CYCLES, sb.errors);
		if (sb.errors == 0) begin
			$display("tb_font_glyph_rasterizer passed");
		end else begin
			$display("tb_font_glyph_rasterizer failed");
		end
		$finish;
	end

endmodule
